// ===== design/aid_pkg.sv =====
// Package with mnemonic codes, value kind codes and stage payload types.
package aid_pkg;

  typedef enum logic [5:0] {
    MN_NOP = 6'd0, MN_PACIBSP = 6'd1, MN_RET = 6'd2, MN_SVC = 6'd3, MN_B = 6'd4,
    MN_BL = 6'd5, MN_BCOND = 6'd6, MN_CBZ = 6'd7, MN_CBNZ = 6'd8, MN_TBZ = 6'd9,
    MN_TBNZ = 6'd10, MN_MOVZ = 6'd11, MN_MOVN = 6'd12, MN_MOVK = 6'd13,
    MN_ADD = 6'd14, MN_SUB = 6'd15, MN_ADDS = 6'd16, MN_SUBS = 6'd17,
    MN_CMP = 6'd18, MN_CMN = 6'd19, MN_MOV = 6'd20, MN_LDR = 6'd21,
    MN_STR = 6'd22, MN_LDRH = 6'd23, MN_STRH = 6'd24, MN_LDRB = 6'd25,
    MN_STRB = 6'd26, MN_LDP = 6'd27, MN_STP = 6'd28, MN_ADRP = 6'd29,
    MN_ADR = 6'd30, MN_BR = 6'd31, MN_BLR = 6'd32, MN_MUL = 6'd33,
    MN_WORD = 6'd34
  } mnem_t;

  // How the final value is formed from the operand and the program counter.
  typedef enum logic [1:0] {
    VK_IMM  = 2'd0,
    VK_PC   = 2'd1,
    VK_PAGE = 2'd2
  } vkind_t;

  typedef struct packed {
    mnem_t       mnemonic;
    logic [3:0]  cond;
    logic        wide;
    logic [4:0]  reg_d;
    logic [4:0]  reg_n;
    logic [4:0]  reg_m;
    logic [5:0]  shift_or_bit;
    logic [1:0]  access_log2;
  } dec_t;

  typedef struct packed {
    dec_t        dec;
    vkind_t      vkind;
    logic [63:0] opnd;
    logic [63:0] pc;
  } mid_t;

  typedef struct packed {
    dec_t        dec;
    logic [63:0] value;
  } res_t;

endpackage

// ===== design/aid_match.sv =====
// Stage one: matches the instruction word and extracts registers and the raw operand.
module aid_match (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  logic [31:0]    insn_word,
  input  logic [63:0]    pc,
  output logic           vld_r,
  output aid_pkg::mid_t  mid_r
);

  aid_pkg::mid_t m;
  logic [31:0]   w;
  logic          sf;
  logic [31:0]   top;
  logic          sub;
  logic          s;
  logic [1:0]    size;
  logic [20:0]   adr_imm;

  always_comb begin
    w = insn_word;
    sf = w[31];
    top = w & 32'h7FE0_0000;
    sub = w[30];
    s = w[29];
    size = w[31:30];
    adr_imm = {w[23:5], w[30:29]};
    m = '0;
    m.pc = pc;
    m.vkind = aid_pkg::VK_IMM;
    m.dec.mnemonic = aid_pkg::MN_WORD;
    if (w == 32'hD503_201F) begin
      m.dec.mnemonic = aid_pkg::MN_NOP;
    end else if (w == 32'hD503_237F) begin
      m.dec.mnemonic = aid_pkg::MN_PACIBSP;
    end else if (w == 32'hD65F_03C0) begin
      m.dec.mnemonic = aid_pkg::MN_RET;
      m.dec.wide = 1'b1;
      m.dec.reg_n = 5'd30;
    end else if (w == 32'hD400_0001) begin
      m.dec.mnemonic = aid_pkg::MN_SVC;
    end else if ((w & 32'h7C00_0000) == 32'h1400_0000) begin
      m.dec.mnemonic = w[26] ? aid_pkg::MN_BL : aid_pkg::MN_B;
      m.vkind = aid_pkg::VK_PC;
      m.opnd = {{36{w[25]}}, w[25:0], 2'b00};
    end else if ((w & 32'hFF00_0010) == 32'h5400_0000) begin
      m.dec.mnemonic = aid_pkg::MN_BCOND;
      m.dec.cond = w[3:0];
      m.vkind = aid_pkg::VK_PC;
      m.opnd = {{43{w[23]}}, w[23:5], 2'b00};
    end else if ((w & 32'h7E00_0000) == 32'h3400_0000) begin
      m.dec.mnemonic = w[24] ? aid_pkg::MN_CBNZ : aid_pkg::MN_CBZ;
      m.dec.wide = sf;
      m.dec.reg_d = w[4:0];
      m.vkind = aid_pkg::VK_PC;
      m.opnd = {{43{w[23]}}, w[23:5], 2'b00};
    end else if ((w & 32'h7E00_0000) == 32'h3600_0000) begin
      m.dec.mnemonic = w[24] ? aid_pkg::MN_TBNZ : aid_pkg::MN_TBZ;
      m.dec.wide = 1'b1;
      m.dec.reg_d = w[4:0];
      m.dec.shift_or_bit = {sf, w[23:19]};
      m.vkind = aid_pkg::VK_PC;
      m.opnd = {{48{w[18]}}, w[18:5], 2'b00};
    end else if (top == 32'h5280_0000 || top == 32'h1280_0000 || top == 32'h7280_0000) begin
      m.dec.mnemonic = (top == 32'h5280_0000) ? aid_pkg::MN_MOVZ :
                       (top == 32'h1280_0000) ? aid_pkg::MN_MOVN : aid_pkg::MN_MOVK;
      m.dec.wide = sf;
      m.dec.reg_d = w[4:0];
      m.opnd = {48'd0, w[20:5]};
      m.dec.shift_or_bit = {w[22:21], 4'd0};
    end else if ((w & 32'h1F00_0000) == 32'h1100_0000) begin
      m.dec.wide = sf;
      m.dec.reg_d = w[4:0];
      m.dec.reg_n = w[9:5];
      m.opnd = w[22] ? {40'd0, w[21:10], 12'd0} : {52'd0, w[21:10]};
      if (s && w[4:0] == 5'd31) begin
        m.dec.mnemonic = sub ? aid_pkg::MN_CMP : aid_pkg::MN_CMN;
      end else begin
        m.dec.mnemonic = sub ? (s ? aid_pkg::MN_SUBS : aid_pkg::MN_SUB)
                             : (s ? aid_pkg::MN_ADDS : aid_pkg::MN_ADD);
      end
    end else if ((w & 32'h1F20_0000) == 32'h0B00_0000) begin
      m.dec.wide = sf;
      m.dec.reg_d = w[4:0];
      m.dec.reg_n = w[9:5];
      m.dec.reg_m = w[20:16];
      if (s && w[4:0] == 5'd31) begin
        m.dec.mnemonic = sub ? aid_pkg::MN_CMP : aid_pkg::MN_CMN;
      end else begin
        m.dec.mnemonic = sub ? (s ? aid_pkg::MN_SUBS : aid_pkg::MN_SUB)
                             : (s ? aid_pkg::MN_ADDS : aid_pkg::MN_ADD);
      end
    end else if ((w & 32'h7FE0_FFE0) == 32'h2A00_03E0) begin
      m.dec.mnemonic = aid_pkg::MN_MOV;
      m.dec.wide = sf;
      m.dec.reg_d = w[4:0];
      m.dec.reg_n = 5'd31;
      m.dec.reg_m = w[20:16];
    end else if ((w & 32'h3B00_0000) == 32'h3900_0000) begin
      if (size[1]) begin
        m.dec.mnemonic = w[22] ? aid_pkg::MN_LDR : aid_pkg::MN_STR;
      end else if (size[0]) begin
        m.dec.mnemonic = w[22] ? aid_pkg::MN_LDRH : aid_pkg::MN_STRH;
      end else begin
        m.dec.mnemonic = w[22] ? aid_pkg::MN_LDRB : aid_pkg::MN_STRB;
      end
      m.dec.wide = (size == 2'd3);
      m.dec.reg_d = w[4:0];
      m.dec.reg_n = w[9:5];
      m.dec.access_log2 = size;
      m.opnd = {52'd0, w[21:10]} << size;
    end else if ((w & 32'h7C00_0000) == 32'h2800_0000) begin
      m.dec.mnemonic = w[22] ? aid_pkg::MN_LDP : aid_pkg::MN_STP;
      m.dec.wide = sf;
      m.dec.reg_d = w[4:0];
      m.dec.reg_n = w[9:5];
      m.dec.reg_m = w[14:10];
      m.dec.access_log2 = sf ? 2'd3 : 2'd2;
      m.opnd = sf ? {{54{w[21]}}, w[21:15], 3'd0} : {{55{w[21]}}, w[21:15], 2'd0};
    end else if ((w & 32'h9F00_0000) == 32'h9000_0000) begin
      m.dec.mnemonic = aid_pkg::MN_ADRP;
      m.dec.wide = 1'b1;
      m.dec.reg_d = w[4:0];
      m.vkind = aid_pkg::VK_PAGE;
      m.opnd = {{31{adr_imm[20]}}, adr_imm, 12'd0};
    end else if ((w & 32'h9F00_0000) == 32'h1000_0000) begin
      m.dec.mnemonic = aid_pkg::MN_ADR;
      m.dec.wide = 1'b1;
      m.dec.reg_d = w[4:0];
      m.vkind = aid_pkg::VK_PC;
      m.opnd = {{43{adr_imm[20]}}, adr_imm};
    end else if ((w & 32'hFFFF_FC1F) == 32'hD63F_0000) begin
      m.dec.mnemonic = aid_pkg::MN_BLR;
      m.dec.wide = 1'b1;
      m.dec.reg_n = w[9:5];
    end else if ((w & 32'hFFFF_FC1F) == 32'hD61F_0000) begin
      m.dec.mnemonic = aid_pkg::MN_BR;
      m.dec.wide = 1'b1;
      m.dec.reg_n = w[9:5];
    end else if ((w & 32'hFFFF_FC1F) == 32'hD65F_0000) begin
      m.dec.mnemonic = aid_pkg::MN_RET;
      m.dec.wide = 1'b1;
      m.dec.reg_n = w[9:5];
    end else if ((w & 32'h7FE0_FC00) == 32'h1B00_7C00) begin
      m.dec.mnemonic = aid_pkg::MN_MUL;
      m.dec.wide = sf;
      m.dec.reg_d = w[4:0];
      m.dec.reg_n = w[9:5];
      m.dec.reg_m = w[20:16];
    end else if ((w & 32'hFFE0_001F) == 32'hD400_0001) begin
      m.dec.mnemonic = aid_pkg::MN_SVC;
      m.opnd = {48'd0, w[20:5]};
    end else begin
      m.opnd = {32'd0, w};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mid_r <= m;
    end
  end

endmodule

// ===== design/aid_addr.sv =====
// Stages two and three: forms the value with a split 64-bit address add.
module aid_addr (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  aid_pkg::mid_t  mid,
  output logic           vld_r,
  output aid_pkg::res_t  res_r
);

  logic          v2_r;
  aid_pkg::dec_t dec2_r;
  logic [31:0]   lo2_r;
  logic          cy2_r;
  logic          add2_r;
  logic [31:0]   ahi2_r;
  logic [31:0]   bhi2_r;
  logic [63:0]   base;
  logic [32:0]   lo_sum;
  aid_pkg::res_t res_nxt;

  always_comb begin
    case (mid.vkind)
      aid_pkg::VK_PC:   base = mid.pc;
      aid_pkg::VK_PAGE: base = {mid.pc[63:12], 12'd0};
      default:          base = 64'd0;
    endcase
    lo_sum = {1'b0, base[31:0]} + {1'b0, mid.opnd[31:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      vld_r <= 1'b0;
    end else if (adv) begin
      v2_r <= in_vld;
      vld_r <= v2_r;
    end
  end

  always_comb begin
    res_nxt.dec = dec2_r;
    res_nxt.value = {ahi2_r + bhi2_r + {31'd0, cy2_r & add2_r}, lo2_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dec2_r <= mid.dec;
      lo2_r <= lo_sum[31:0];
      cy2_r <= lo_sum[32];
      add2_r <= (mid.vkind != aid_pkg::VK_IMM);
      ahi2_r <= base[63:32];
      bhi2_r <= mid.opnd[63:32];
      res_r <= res_nxt;
    end
  end

endmodule

// ===== design/arm64_instruction_decoder_core.sv =====
// Top level of the A64 instruction decoder pipeline.
// The decoder takes one instruction word with its program counter on the in_ channel
// and gives one decoded request on the out_ channel for each request taken.
// The pipeline has three register stages: match and field extraction, low half of the
// address add, and high half of the address add; one request can be accepted in every
// cycle while no result waits unaccepted at the output.
// The whole pipeline advances together whenever its last stage is empty or the
// receiver takes the result, so in_ready is low only while a result waits at the output.
// When the receiver stalls with a result waiting, every stage holds and in_ready
// drops, even if earlier stages are empty; nothing is lost or repeated.
// Synchronous reset clears all valid bits; the data registers are not reset.
// Unused result fields read as zero; unrecognized words return the mnemonic code
// for a raw word with the word itself as the value.
module arm64_instruction_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_insn_word,
  input  logic [63:0] in_pc,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_mnemonic,
  output logic [3:0]  out_cond,
  output logic        out_wide,
  output logic [4:0]  out_reg_d,
  output logic [4:0]  out_reg_n,
  output logic [4:0]  out_reg_m,
  output logic [63:0] out_value,
  output logic [5:0]  out_shift_or_bit,
  output logic [1:0]  out_access_log2
);

  logic          adv;
  logic          v1;
  aid_pkg::mid_t mid;
  aid_pkg::res_t res;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  aid_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (in_valid),
    .insn_word (in_insn_word),
    .pc        (in_pc),
    .vld_r     (v1),
    .mid_r     (mid)
  );

  aid_addr u_addr (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (v1),
    .mid    (mid),
    .vld_r  (out_valid),
    .res_r  (res)
  );

  assign out_mnemonic     = res.dec.mnemonic;
  assign out_cond         = res.dec.cond;
  assign out_wide         = res.dec.wide;
  assign out_reg_d        = res.dec.reg_d;
  assign out_reg_n        = res.dec.reg_n;
  assign out_reg_m        = res.dec.reg_m;
  assign out_value        = res.value;
  assign out_shift_or_bit = res.dec.shift_or_bit;
  assign out_access_log2  = res.dec.access_log2;

endmodule
